/* sv/morse_key_hex_decoder_defines.svh */
// assertion macros for the morse key hex decoder
`ifndef MORSE_KEY_HEX_DECODER_DEFINES_SVH
`define MORSE_KEY_HEX_DECODER_DEFINES_SVH

// plain property, checked outside reset
`define MKHD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication, checked outside reset
`define MKHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/mkhd_pkg.sv */
// types, constants and code tables for the morse key hex decoder
package mkhd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_TICKS    = 2'd0,
        CFG_MIN_HOLD_TICKS  = 2'd1,
        CFG_DASH_TICKS      = 2'd2,
        CFG_DISPLAY_PERIODS = 2'd3
    } t_cfg_idx;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_PIN  = 1'b1;

    localparam logic [15:0] RST_PERIOD_TICKS    = 16'd50005;
    localparam logic [15:0] RST_MIN_HOLD_TICKS  = 16'd3750;
    localparam logic [15:0] RST_DASH_TICKS      = 16'd25000;
    localparam logic [3:0]  RST_DISPLAY_PERIODS = 4'd5;

    localparam logic [3:0] PERIOD_COUNT_MAX = 4'd15;

    localparam logic [7:0] SEG_DECIMAL = 8'h08;
    localparam logic [7:0] SEG_DASH    = 8'h80;

    localparam logic [7:0] SEG_TABLE [16] = '{
        8'h77, 8'h14, 8'hB3, 8'hB6, 8'hD4, 8'hE6, 8'hE7, 8'h34,
        8'hF7, 8'hF6, 8'hF5, 8'hC7, 8'h63, 8'h97, 8'hE3, 8'hE1
    };

    // mark count per hex digit
    localparam logic [3:0] CODE_LEN [16] = '{
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4
    };

    // bit i is mark i, 1 = dash
    localparam logic [4:0] CODE_BITS [16] = '{
        5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03,
        5'h07, 5'h0F, 5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04
    };

    typedef struct packed {
        logic       hit;
        logic [7:0] seg;
    } t_lookup;

    function automatic t_lookup mkhd_lookup(input logic [3:0] len, input logic [4:0] code);
        t_lookup res;
        res.hit = 1'b0;
        res.seg = SEG_DECIMAL;
        for (int i = 15; i >= 0; i--) begin
            if (len == CODE_LEN[i] && code == CODE_BITS[i]) begin
                res.hit = 1'b1;
                res.seg = SEG_TABLE[i];
            end
        end
        return res;
    endfunction

endpackage

/* sv/mkhd_in_if.sv */
// input channel: one tick or pin change beat
interface mkhd_in_if;
    logic valid;
    logic ready;
    logic func;
    logic key_pressed;
    logic clear_pressed;

    modport source (output valid, output func, output key_pressed, output clear_pressed,
                    input ready);
    modport sink   (input valid, input func, input key_pressed, input clear_pressed,
                    output ready);
endinterface

/* sv/mkhd_out_if.sv */
// output channel: display state beat
interface mkhd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic       showing;
    logic [2:0] mark_count;

    modport source (output valid, output segments, output showing, output mark_count,
                    input ready);
    modport sink   (input valid, input segments, input showing, input mark_count,
                    output ready);
endinterface

/* sv/morse_key_hex_decoder.sv */
// morse key hex decoder top level
//
//   channel  dir  beat payload                              handshake
//   i_in     in   func, key_pressed, clear_pressed          valid/ready
//   o_out    out  segments, showing, mark_count             valid/ready
//   i_cfg_*  in   register index, 16-bit data               write enable only
//
// one beat per cycle: each accepted beat updates the state and loads the
// output register in the same cycle, so a result appears in the following cycle.
// i_in.ready drops only while the output register is full and o_out.ready is low.
// reset is synchronous: control state, config registers and output valid reset; mark bits and output data do not.
`include "morse_key_hex_decoder_defines.svh"

module morse_key_hex_decoder
    import mkhd_pkg::*;
#(
    parameter int MAX_MARKS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mkhd_in_if.sink               i_in,
    mkhd_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LEN_W = $clog2(MAX_MARKS + 1);
    localparam int IDX_W = $clog2(MAX_MARKS);

    logic [15:0] r_period_ticks, r_min_hold_ticks, r_dash_ticks;
    logic [3:0]  r_display_periods;

    logic [15:0]          r_gap_counter,  n_gap_counter;
    logic [3:0]           r_period_count, n_period_count;
    logic                 r_display_on,   n_display_on;
    logic                 r_key_held,     n_key_held;
    logic [MAX_MARKS-1:0] r_mark_bits,    n_mark_bits;
    logic [LEN_W-1:0]     r_mark_len,     n_mark_len;
    logic [7:0]           r_segment_reg,  n_segment_reg;

    logic       r_out_valid;
    logic [7:0] r_out_segments;
    logic       r_out_showing;
    logic [2:0] r_out_mark_count;

    logic        in_acc;
    logic [16:0] next_gap;
    logic [4:0]  code;
    t_lookup     lookup;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ticks    <= RST_PERIOD_TICKS;
            r_min_hold_ticks  <= RST_MIN_HOLD_TICKS;
            r_dash_ticks      <= RST_DASH_TICKS;
            r_display_periods <= RST_DISPLAY_PERIODS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIOD_TICKS:    r_period_ticks    <= i_cfg_data;
                CFG_MIN_HOLD_TICKS:  r_min_hold_ticks  <= i_cfg_data;
                CFG_DASH_TICKS:      r_dash_ticks      <= i_cfg_data;
                CFG_DISPLAY_PERIODS: r_display_periods <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // buffered marks below the fill count form the code
    always_comb begin
        for (int i = 0; i < $bits(code); i++) begin
            code[i] = r_mark_bits[i] && (LEN_W'(i) < r_mark_len);
        end
    end

    assign lookup   = mkhd_lookup(4'(r_mark_len), code);
    assign next_gap = {1'b0, r_gap_counter} + 17'd1;

    always_comb begin
        n_gap_counter  = r_gap_counter;
        n_period_count = r_period_count;
        n_display_on   = r_display_on;
        n_key_held     = r_key_held;
        n_mark_bits    = r_mark_bits;
        n_mark_len     = r_mark_len;
        n_segment_reg  = r_segment_reg;

        if (in_acc) begin
            if (i_in.func == FUNC_TICK) begin
                if (next_gap >= {1'b0, r_period_ticks}) begin
                    // period end
                    n_gap_counter = '0;
                    if (r_period_count > r_display_periods && r_display_on) begin
                        n_segment_reg  = '0;
                        n_display_on   = 1'b0;
                        n_period_count = '0;
                        n_key_held     = 1'b0;
                        n_mark_len     = '0;
                    end else if (r_display_on && r_period_count != '0) begin
                        if (r_period_count < PERIOD_COUNT_MAX) begin
                            n_period_count = r_period_count + 4'd1;
                        end
                    end else if (r_period_count != '0 && r_key_held) begin
                        // key held too long
                        n_segment_reg  = SEG_DECIMAL | SEG_DASH;
                        n_display_on   = 1'b1;
                        n_period_count = 4'd1;
                    end else if (r_period_count != '0) begin
                        n_period_count = 4'd1;
                        n_display_on   = 1'b1;
                        n_segment_reg  = lookup.seg;
                        if (!lookup.hit) begin
                            n_mark_len = '0;
                        end
                    end
                end else begin
                    n_gap_counter = next_gap[15:0];
                end
            end else begin
                n_gap_counter = '0;
                if (i_in.clear_pressed) begin
                    n_segment_reg  = '0;
                    n_display_on   = 1'b0;
                    n_period_count = '0;
                    n_key_held     = 1'b0;
                    n_mark_len     = '0;
                end else if (r_display_on) begin
                    // key ignored while showing
                end else if (i_in.key_pressed) begin
                    if (r_mark_len != '0 && r_gap_counter < r_min_hold_ticks) begin
                        // pause too short
                        n_gap_counter = r_gap_counter;
                    end else begin
                        n_period_count = 4'd1;
                        n_key_held     = 1'b1;
                    end
                end else if (r_key_held) begin
                    n_key_held     = 1'b0;
                    n_period_count = 4'd1;
                    if (r_gap_counter < r_min_hold_ticks) begin
                        n_segment_reg = SEG_DASH;
                        n_display_on  = 1'b1;
                    end else if (r_mark_len < LEN_W'(MAX_MARKS)) begin
                        n_mark_bits[r_mark_len[IDX_W-1:0]] = (r_gap_counter >= r_dash_ticks);
                        n_mark_len = r_mark_len + LEN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_counter  <= '0;
            r_period_count <= '0;
            r_display_on   <= 1'b0;
            r_key_held     <= 1'b0;
            r_mark_len     <= '0;
            r_segment_reg  <= '0;
        end else begin
            r_gap_counter  <= n_gap_counter;
            r_period_count <= n_period_count;
            r_display_on   <= n_display_on;
            r_key_held     <= n_key_held;
            r_mark_len     <= n_mark_len;
            r_segment_reg  <= n_segment_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mark_bits <= n_mark_bits;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_segments   <= n_segment_reg;
            r_out_showing    <= n_display_on;
            r_out_mark_count <= n_mark_len[2:0];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.segments   = r_out_segments;
    assign o_out.showing    = r_out_showing;
    assign o_out.mark_count = r_out_mark_count;

    `MKHD_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, in_acc && i_in.func == FUNC_PIN && i_in.clear_pressed, !r_display_on && r_mark_len == '0 && !r_key_held, "clear beat did not empty the state")
    `MKHD_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !in_acc, $stable(r_gap_counter) && $stable(r_mark_len) && $stable(r_segment_reg), "state changed without a beat")
    `MKHD_ASSERT_NEXT(a_out_tracks, i_clk, i_rst_n, in_acc, r_out_valid && r_out_segments == r_segment_reg && r_out_mark_count == r_mark_len[2:0], "output beat does not match state")
    `MKHD_ASSERT(a_show_starts, i_clk, i_rst_n, $rose(r_display_on) |-> r_period_count == 4'd1, "display started with wrong period count")
    `MKHD_ASSERT_NEXT(a_len_step, i_clk, i_rst_n, 1'b1, r_mark_len == $past(r_mark_len) || r_mark_len == $past(r_mark_len) + LEN_W'(1) || r_mark_len == '0, "mark count jumped")

endmodule

/* bench/morse_key_hex_decoder_test.sv */
// self-checking bench for the morse key hex decoder: directed keying, random digits, backpressure
module morse_key_hex_decoder_test
    import mkhd_pkg::*;
();

    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;

    typedef struct packed {
        logic [7:0] segments;
        logic       showing;
        logic [2:0] mark_count;
    } t_display_beat;

    // hex digit patterns, mark counts and mark codes (bit i = mark i, 1 = dash)
    localparam logic [7:0] DIGIT_SEG [16] = '{
        8'h77, 8'h14, 8'hB3, 8'hB6, 8'hD4, 8'hE6, 8'hE7, 8'h34,
        8'hF7, 8'hF6, 8'hF5, 8'hC7, 8'h63, 8'h97, 8'hE3, 8'hE1
    };
    localparam int DIGIT_LEN [16] = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 2, 4, 4, 3, 1, 4};
    localparam logic [6:0] DIGIT_CODE [16] = '{
        7'h1F, 7'h1E, 7'h1C, 7'h18, 7'h10, 7'h00, 7'h01, 7'h03,
        7'h07, 7'h0F, 7'h02, 7'h01, 7'h05, 7'h01, 7'h00, 7'h04
    };

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mkhd_in_if  in_if ();
    mkhd_out_if out_if ();

    morse_key_hex_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // decoder state as predicted
    logic [15:0] cfg_period, cfg_min_hold, cfg_dash;
    logic [3:0]  cfg_display;
    logic [15:0] gap_ticks;
    logic [3:0]  period_cnt;
    logic        disp_on, key_down;
    logic        marks [7];
    logic [2:0]  mark_len;
    logic [7:0]  seg_shown;

    t_display_beat display_beats_due [$];
    t_display_beat want;
    int errors;
    int sent_items;
    int src_idle_pct;
    int snk_idle_pct;
    bit long_hold_req;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_decoder();
        cfg_period   = RST_PERIOD_TICKS;
        cfg_min_hold = RST_MIN_HOLD_TICKS;
        cfg_dash     = RST_DASH_TICKS;
        cfg_display  = RST_DISPLAY_PERIODS;
        gap_ticks    = '0;
        period_cnt   = '0;
        disp_on      = 1'b0;
        key_down     = 1'b0;
        mark_len     = '0;
        seg_shown    = '0;
        foreach (marks[i]) marks[i] = 1'b0;
    endfunction

    function automatic void clear_display();
        seg_shown  = '0;
        disp_on    = 1'b0;
        period_cnt = '0;
        key_down   = 1'b0;
        mark_len   = '0;
    endfunction

    function automatic void decode_marks();
        logic [6:0] code;
        bit hit;
        code = '0;
        hit  = 1'b0;
        for (int i = 0; i < 7; i++)
            if (i < mark_len && marks[i]) code[i] = 1'b1;
        period_cnt = 4'd1;
        disp_on    = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (!hit && int'(mark_len) == DIGIT_LEN[i] && code == DIGIT_CODE[i]) begin
                seg_shown = DIGIT_SEG[i];
                hit = 1'b1;
            end
        end
        if (!hit) begin
            seg_shown = SEG_DECIMAL;
            mark_len  = '0;
        end
    endfunction

    function automatic void end_of_period();
        if (disp_on && period_cnt > cfg_display) begin
            clear_display();
        end else if (disp_on && period_cnt > 0) begin
            if (period_cnt < PERIOD_COUNT_MAX) period_cnt++;
        end else if (period_cnt > 0 && key_down) begin
            seg_shown  = SEG_DECIMAL | SEG_DASH;
            disp_on    = 1'b1;
            period_cnt = 4'd1;
        end else if (period_cnt > 0) begin
            decode_marks();
        end
    endfunction

    function automatic t_display_beat advance_decoder(logic func, logic key, logic clr);
        t_display_beat res;
        logic [16:0] next;
        logic [15:0] measured;
        if (func == FUNC_TICK) begin
            next = {1'b0, gap_ticks} + 17'd1;
            if (next >= {1'b0, cfg_period}) begin
                gap_ticks = '0;
                end_of_period();
            end else begin
                gap_ticks = next[15:0];
            end
        end else begin
            measured  = gap_ticks;
            gap_ticks = '0;
            if (clr) begin
                clear_display();
            end else if (disp_on) begin
            end else if (key) begin
                if (mark_len > 0 && measured < cfg_min_hold) begin
                    gap_ticks = measured;
                end else begin
                    period_cnt = 4'd1;
                    key_down   = 1'b1;
                end
            end else if (key_down) begin
                key_down   = 1'b0;
                period_cnt = 4'd1;
                if (measured < cfg_min_hold) begin
                    seg_shown = SEG_DASH;
                    disp_on   = 1'b1;
                end else if (mark_len < 7) begin
                    marks[mark_len] = (measured >= cfg_dash);
                    mark_len++;
                end
            end
        end
        res.segments   = seg_shown;
        res.showing    = disp_on;
        res.mark_count = mark_len;
        return res;
    endfunction

    // entered and left at a falling edge; valid stays high for a following beat
    task automatic send_beat(logic func, logic key, logic clr);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.func          <= func;
        in_if.key_pressed   <= key;
        in_if.clear_pressed <= clr;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        display_beats_due.push_back(advance_decoder(func, key, clr));
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic tick_n(int n);
        repeat (n) send_beat(FUNC_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic press_key();
        send_beat(FUNC_PIN, 1'b1, 1'b0);
    endtask

    task automatic release_key();
        send_beat(FUNC_PIN, 1'b0, 1'b0);
    endtask

    task automatic press_clear();
        send_beat(FUNC_PIN, 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic noise_burst(int n);
        repeat (n) send_beat(1'($urandom_range(1)), 1'($urandom_range(1)),
                             $urandom_range(7) == 0);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (display_beats_due.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_PERIOD_TICKS:    cfg_period   = val;
            CFG_MIN_HOLD_TICKS:  cfg_min_hold = val;
            CFG_DASH_TICKS:      cfg_dash     = val;
            CFG_DISPLAY_PERIODS: cfg_display  = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(int period, int min_hold, int dash, int disp);
        write_reg(CFG_PERIOD_TICKS, period[15:0]);
        write_reg(CFG_MIN_HOLD_TICKS, min_hold[15:0]);
        write_reg(CFG_DASH_TICKS, dash[15:0]);
        write_reg(CFG_DISPLAY_PERIODS, disp[15:0]);
    endtask

    task automatic key_digit();
        int len, p, m, d, hold, k;
        logic [8:0] bits;
        p = int'(cfg_period);
        m = int'(cfg_min_hold);
        d = int'(cfg_dash);
        if ($urandom_range(3) != 0) begin
            k    = $urandom_range(15);
            len  = DIGIT_LEN[k];
            bits = {2'b00, DIGIT_CODE[k]};
        end else begin
            len  = $urandom_range(9, 1);
            bits = 9'($urandom);
        end
        for (int i = 0; i < len; i++) begin
            press_key();
            k = $urandom_range(19);
            if (k == 0 && m > 0) hold = 0;
            else if (k == 1) hold = p + $urandom_range(2);
            else if (bits[i]) hold = $urandom_range(p - 1, d);
            else hold = $urandom_range(d - 1, m);
            tick_n(hold);
            release_key();
            if (i < len - 1) tick_n(($urandom_range(14) == 0) ? 0 : $urandom_range(p - 1, m));
        end
        tick_n(p + $urandom_range(2));
        if (cfg_display == 4'd15) tick_n($urandom_range(3 * p, p));
        else tick_n((int'(cfg_display) + 2) * p);
        if (cfg_display == 4'd15 || $urandom_range(2) == 0) press_clear();
    endtask

    task automatic test_digit_entry();
        configure(2, 0, 1, 0);
        release_key();
        press_key();
        release_key();
        tick_n(1);
        press_key();
        tick_n(1);
        release_key();
        tick_n(2);
        tick_n(2);
    endtask

    task automatic test_short_hold_and_pause();
        configure(3, 1, 2, 15);
        press_key();
        release_key();
        press_key();
        press_clear();
        press_key();
        tick_n(1);
        release_key();
        press_key();
        press_clear();
    endtask

    task automatic test_fault_pattern();
        write_reg(CFG_PERIOD_TICKS, 16'd1);
        press_key();
        tick_n(1);
        press_clear();
    endtask

    task automatic test_period_lowered();
        configure(65535, 65535, 65535, 15);
        press_key();
        tick_n(3);
        write_reg(CFG_PERIOD_TICKS, 16'd0);
        tick_n(1);
        press_clear();
        write_reg(CFG_PERIOD_TICKS, 16'd65535);
        press_key();
        release_key();
        press_clear();
    endtask

    task automatic test_backpressure();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        long_hold_req = 1'b1;
        @(negedge i_clk);
        noise_burst(40);
    endtask

    task automatic test_random_keying(int target, int extreme);
        int start, p, m, d, r;
        start = sent_items;
        case (extreme)
            0: configure(65535, 65535, 65535, 15);
            1: configure(1, 0, 0, 0);
            default: configure(RST_PERIOD_TICKS, RST_MIN_HOLD_TICKS, RST_DASH_TICKS,
                               RST_DISPLAY_PERIODS);
        endcase
        noise_burst(40);
        while (sent_items - start < target) begin
            p = $urandom_range(12, 4);
            m = $urandom_range(1);
            d = $urandom_range(p - 2, m + 1);
            r = $urandom_range(5);
            configure(p, m, d, (r == 5) ? 15 : r);
            repeat ($urandom_range(4, 2)) begin
                key_digit();
                if ($urandom_range(3) == 0) noise_burst($urandom_range(12, 3));
            end
        end
    endtask

    // receiver: random idling plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (display_beats_due.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = display_beats_due.pop_front();
                if (out_if.segments !== want.segments) begin
                    $error("segments: expected %h, got %h", want.segments, out_if.segments);
                    errors++;
                end
                if (out_if.showing !== want.showing) begin
                    $error("showing: expected %b, got %b", want.showing, out_if.showing);
                    errors++;
                end
                if (out_if.mark_count !== want.mark_count) begin
                    $error("mark_count: expected %0d, got %0d", want.mark_count,
                           out_if.mark_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stuck = 0;
            else stuck++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        errors              = 0;
        sent_items          = 0;
        hold_left           = 0;
        long_hold_req       = 1'b0;
        src_idle_pct        = 27;
        snk_idle_pct        = 50;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        in_if.valid         = 1'b0;
        in_if.func          = FUNC_TICK;
        in_if.key_pressed   = 1'b0;
        in_if.clear_pressed = 1'b0;
        out_if.ready        = 1'b0;
        reset_decoder();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_digit_entry();
        test_short_hold_and_pause();
        test_fault_pattern();
        test_period_lowered();
        test_random_keying(200, 0);

        src_idle_pct = 50;
        snk_idle_pct = 27;
        test_random_keying(200, 1);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_backpressure();
        test_random_keying(200, 2);

        drain();
        repeat (4) @(negedge i_clk);
        if (display_beats_due.size() != 0) begin
            $error("%0d result beats never arrived", display_beats_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* morse_key_hex_decoder.f */
+incdir+sv
sv/mkhd_pkg.sv
sv/mkhd_in_if.sv
sv/mkhd_out_if.sv
sv/morse_key_hex_decoder.sv
bench/morse_key_hex_decoder_test.sv
